>>> design/rmv_pkg.sv
// Shared types, constants and helpers for the running mean/variance block.
`default_nettype none
package rmv_pkg;

  localparam int CountBits = 24;
  localparam int FracBits  = 16;
  localparam int AccBits   = 144;
  localparam int MulBits   = 48;
  localparam int RemBits   = 35;
  localparam int DivBits   = 25;
  localparam int LenBits   = 8;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Shared unit operations
  localparam logic [1:0] KIND_MUL  = 2'd0;
  localparam logic [1:0] KIND_DIV  = 2'd1;
  localparam logic [1:0] KIND_SQRT = 2'd2;

  typedef struct packed {
    logic               start;
    logic [1:0]         kind;
    logic [LenBits-1:0] len;
  } rmv_cmd_t;

  // Saturating 64-bit add; top bit flags saturation
  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      sat_add = {1'b1, {64{1'b1}}};
    end else begin
      sat_add = {1'b0, s[63:0]};
    end
  endfunction

endpackage
`default_nettype wire

>>> design/running_mean_variance.sv
// Top level: sequencer and state of the running mean/variance block.
// Keeps a sample count, running mean and squared deviation; each transaction
// adds one sample or merges a partial summary, then reports count, mean,
// unbiased variance, standard error and flags. All arithmetic runs on one
// bit-serial unit (one quotient or product bit per cycle, one root bit per
// cycle); the variance steps are skipped when fewer than two samples are held,
// and an empty merge runs no unit operation at all. in_stall is high from an
// accepted transaction until its result enters the output register. The
// result sits in an output register until taken, and a new result waits while
// that register is still full.
`default_nettype none
module running_mean_variance (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 op,
  input  wire logic signed [31:0]   sample,
  input  wire logic [23:0]          part_count,
  input  wire logic signed [47:0]   part_mean,
  input  wire logic [63:0]          part_sq_dev,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [23:0]               sample_count,
  output logic signed [31:0]        mean_out,
  output logic [63:0]               variance_out,
  output logic [31:0]               std_error,
  output logic                      mean_ok,
  output logic                      variance_ok,
  output logic                      overflow
);
  import rmv_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_DIV  = 4'd1;
  localparam logic [3:0] S_A_MUL  = 4'd2;
  localparam logic [3:0] S_M_MUL  = 4'd3;
  localparam logic [3:0] S_M_DIV  = 4'd4;
  localparam logic [3:0] S_M_SQ   = 4'd5;
  localparam logic [3:0] S_M_NA   = 4'd6;
  localparam logic [3:0] S_M_NB   = 4'd7;
  localparam logic [3:0] S_M_DIV2 = 4'd8;
  localparam logic [3:0] S_F_VAR  = 4'd9;
  localparam logic [3:0] S_F_SE   = 4'd10;
  localparam logic [3:0] S_F_SQRT = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0]              state;
  logic                    go;
  logic [CountBits-1:0]    count;
  logic signed [47:0]      mean;
  logic [63:0]             sq;
  logic                    ovf;
  logic signed [47:0]      xval;
  logic [47:0]             dmag;
  logic                    dneg;
  logic [CountBits-1:0]    nb;
  logic [CountBits:0]      ntot;
  logic [63:0]             psq;
  logic [63:0]             var_r;
  logic [31:0]             se_r;

  rmv_cmd_t                cmd;
  logic [AccBits-1:0]      a_in;
  logic [AccBits-1:0]      b_in;
  logic [MulBits-1:0]      m_in;
  logic                    done;
  logic [AccBits-1:0]      acc;
  logic [31:0]             root;

  rmv_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .a_in (a_in),
    .b_in (b_in),
    .m_in (m_in),
    .done (done),
    .acc  (acc),
    .root (root)
  );

  // Input-side differences
  logic signed [47:0] x_in;
  logic signed [48:0] d_add;
  logic signed [48:0] d_mrg;
  logic signed [48:0] e_add;
  logic [47:0]        e_mag;
  logic [CountBits:0] n_mrg;
  logic [47:0]        q_lo;
  logic signed [47:0] mean_upd;
  logic [63:0]        term;
  logic               term_sat;
  logic [64:0]        s1;
  logic [64:0]        s2;
  logic [64:0]        s_add;

  assign x_in     = {sample, {FracBits{1'b0}}};
  assign d_add    = {x_in[47], x_in} - {mean[47], mean};
  assign d_mrg    = {part_mean[47], part_mean} - {mean[47], mean};
  assign e_add    = {xval[47], xval} - {mean[47], mean};
  assign e_mag    = e_add[48] ? 48'(-e_add) : e_add[47:0];
  assign n_mrg    = {1'b0, count} + {1'b0, part_count};
  assign q_lo     = acc[47:0];
  assign mean_upd = dneg ? mean - $signed(q_lo) : mean + $signed(q_lo);
  assign term_sat = |acc[AccBits-1:96];
  assign term     = term_sat ? {64{1'b1}} : acc[95:32];
  assign s_add    = sat_add(sq, term);
  assign s1       = sat_add(sq, psq);
  assign s2       = sat_add(s1[63:0], term);

  // Commands to the shared unit
  always_comb begin
    cmd.start = go && (state != S_IDLE) && (state != S_FIN);
    cmd.kind  = KIND_MUL;
    cmd.len   = LenBits'(48);
    a_in      = '0;
    b_in      = '0;
    m_in      = '0;
    unique case (state)
      S_A_DIV: begin
        cmd.kind = KIND_DIV;
        a_in     = {dmag, 96'b0};
        b_in     = AccBits'(ntot);
      end
      S_A_MUL: begin
        b_in = AccBits'(e_mag);
        m_in = dmag;
      end
      S_M_MUL: begin
        cmd.len = LenBits'(24);
        b_in    = AccBits'(dmag);
        m_in    = {nb, 24'b0};
      end
      S_M_DIV: begin
        cmd.kind = KIND_DIV;
        cmd.len  = LenBits'(72);
        a_in     = {acc[71:0], 72'b0};
        b_in     = AccBits'(ntot);
      end
      S_M_SQ: begin
        b_in = AccBits'(dmag);
        m_in = dmag;
      end
      S_M_NA: begin
        cmd.len = LenBits'(24);
        b_in    = acc;
        m_in    = {count, 24'b0};
      end
      S_M_NB: begin
        cmd.len = LenBits'(24);
        b_in    = acc;
        m_in    = {nb, 24'b0};
      end
      S_M_DIV2: begin
        cmd.kind = KIND_DIV;
        cmd.len  = LenBits'(144);
        a_in     = acc;
        b_in     = AccBits'(ntot);
      end
      S_F_VAR: begin
        cmd.kind = KIND_DIV;
        cmd.len  = LenBits'(64);
        cmd.start = go && (count >= CountBits'(2));
        a_in     = {sq, 80'b0};
        b_in     = AccBits'(count - 1'b1);
      end
      S_F_SE: begin
        cmd.kind = KIND_DIV;
        cmd.len  = LenBits'(64);
        a_in     = {var_r, 80'b0};
        b_in     = AccBits'(count);
      end
      S_F_SQRT: begin
        cmd.kind = KIND_SQRT;
        cmd.len  = LenBits'(32);
        a_in     = {acc[63:0], 80'b0};
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      go        <= 1'b0;
      count     <= '0;
      mean      <= '0;
      sq        <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.start) begin
        go <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            go <= 1'b1;
            if (!op) begin
              xval <= x_in;
              dneg <= d_add[48];
              dmag <= d_add[48] ? 48'(-d_add) : d_add[47:0];
              if (count == CountMax) begin
                ovf  <= 1'b1;
                ntot <= {1'b0, count};
              end else begin
                count <= count + 1'b1;
                ntot  <= {1'b0, count} + 1'b1;
              end
              state <= S_A_DIV;
            end else begin
              dneg  <= d_mrg[48];
              dmag  <= d_mrg[48] ? 48'(-d_mrg) : d_mrg[47:0];
              nb    <= part_count;
              psq   <= part_sq_dev;
              ntot  <= n_mrg;
              state <= (n_mrg == '0) ? S_F_VAR : S_M_MUL;
            end
          end
        end
        S_A_DIV: if (done) begin
          mean  <= mean_upd;
          go    <= 1'b1;
          state <= S_A_MUL;
        end
        S_A_MUL: if (done) begin
          sq    <= s_add[63:0];
          ovf   <= ovf | s_add[64] | term_sat;
          go    <= 1'b1;
          state <= S_F_VAR;
        end
        S_M_MUL: if (done) begin
          go    <= 1'b1;
          state <= S_M_DIV;
        end
        S_M_DIV: if (done) begin
          mean  <= mean_upd;
          go    <= 1'b1;
          state <= S_M_SQ;
        end
        S_M_SQ: if (done) begin
          go    <= 1'b1;
          state <= S_M_NA;
        end
        S_M_NA: if (done) begin
          go    <= 1'b1;
          state <= S_M_NB;
        end
        S_M_NB: if (done) begin
          go    <= 1'b1;
          state <= S_M_DIV2;
        end
        S_M_DIV2: if (done) begin
          sq  <= s2[63:0];
          ovf <= ovf | s1[64] | s2[64] | term_sat | ntot[CountBits];
          count <= ntot[CountBits] ? CountMax : ntot[CountBits-1:0];
          go    <= 1'b1;
          state <= S_F_VAR;
        end
        S_F_VAR: begin
          if (count < CountBits'(2)) begin
            var_r <= '0;
            se_r  <= '0;
            go    <= 1'b0;
            state <= S_FIN;
          end else if (done) begin
            var_r <= acc[63:0];
            go    <= 1'b1;
            state <= S_F_SE;
          end
        end
        S_F_SE: if (done) begin
          go    <= 1'b1;
          state <= S_F_SQRT;
        end
        S_F_SQRT: if (done) begin
          se_r  <= root;
          go    <= 1'b0;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!out_valid || !out_stall)) begin
      sample_count <= count;
      mean_out     <= (count != '0) ? mean[47:FracBits] : '0;
      variance_out <= var_r;
      std_error    <= se_r;
      mean_ok      <= (count != '0);
      variance_ok  <= (count >= CountBits'(2));
      overflow     <= ovf;
    end
  end

endmodule
`default_nettype wire

>>> design/rmv_unit.sv
// Shared bit-serial unit: shift-add multiply, restoring divide, square root.
`default_nettype none
module rmv_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rmv_pkg::rmv_cmd_t             cmd,
  input  wire logic [rmv_pkg::AccBits-1:0]   a_in,
  input  wire logic [rmv_pkg::AccBits-1:0]   b_in,
  input  wire logic [rmv_pkg::MulBits-1:0]   m_in,
  output logic                               done,
  output logic [rmv_pkg::AccBits-1:0]        acc,
  output logic [31:0]                        root
);
  import rmv_pkg::*;

  logic                busy;
  logic [1:0]          kind;
  logic [LenBits-1:0]  cnt;
  logic [AccBits-1:0]  mcand;
  logic [MulBits-1:0]  mplier;
  logic [DivBits-1:0]  divisor;
  logic [RemBits-1:0]  rem;

  logic [DivBits:0]    dtrial;
  logic [RemBits-1:0]  strial;
  logic [RemBits-1:0]  sroot;

  assign dtrial = {rem[DivBits-1:0], acc[AccBits-1]};
  assign strial = {rem[RemBits-3:0], acc[AccBits-1:AccBits-2]};
  assign sroot  = {1'b0, root, 2'b01};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !cmd.start && (cnt == LenBits'(1));
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.len;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == LenBits'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: one bit (two for root) per cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind    <= cmd.kind;
      rem     <= '0;
      root    <= '0;
      mcand   <= b_in;
      divisor <= b_in[DivBits-1:0];
      mplier  <= m_in;
      acc     <= (cmd.kind == KIND_MUL) ? '0 : a_in;
    end else if (busy) begin
      unique case (kind)
        KIND_MUL: begin
          acc    <= {acc[AccBits-2:0], 1'b0} + (mplier[MulBits-1] ? mcand : '0);
          mplier <= {mplier[MulBits-2:0], 1'b0};
        end
        KIND_DIV: begin
          if (dtrial >= {1'b0, divisor}) begin
            rem <= RemBits'(dtrial - {1'b0, divisor});
            acc <= {acc[AccBits-2:0], 1'b1};
          end else begin
            rem <= RemBits'(dtrial);
            acc <= {acc[AccBits-2:0], 1'b0};
          end
        end
        default: begin
          acc <= {acc[AccBits-3:0], 2'b00};
          if (strial >= sroot) begin
            rem  <= strial - sroot;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= strial;
            root <= {root[30:0], 1'b0};
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire
